### hw/rtl/srt_pkg.sv
// Shared types, codes and default sizes of the slot reservation table.
`default_nettype none
package srt_pkg;

  localparam int MAX_RESOURCES_DEF = 64;
  localparam int MAX_SITES_DEF     = 16;
  localparam int KEY_BITS_DEF      = 64;
  localparam int KEY_W             = 64;
  localparam int DAYS              = 7;
  localparam int MAX_RESULTS       = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam int REQ_W             = 2;
  localparam int SIDX_W            = 4;
  localparam int DAY_W             = 3;
  localparam int STATUS_W          = 3;
  localparam int ENTRY_W           = 6;
  localparam int ROW_SITE_W        = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_SITE = 2'd0,
    REQ_ADD_RES  = 2'd1,
    REQ_RESERVE  = 2'd2,
    REQ_QUERY    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4,
    ST_TAKEN     = 3'd5,
    ST_NO_SITES  = 3'd6
  } status_t;

  typedef struct packed {
    req_t              req;
    logic [KEY_W-1:0]  rkey;
    logic [KEY_W-1:0]  skey;
    logic [SIDX_W-1:0] sidx;
    logic [DAY_W-1:0]  day;
    logic              day_bad;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

### hw/rtl/slot_reservation_table_core.sv
// Top level of the slot reservation table: front end, request queue and back end.
// Each request is served after a serial scan over the stored keys; a slot claim adds a
// read-modify-write step and a query streams its rows back to back. The back end takes
// the next queued request only when idle; the receiver cannot stall, so results never wait.
// Reset clears counts and control; a new resource row is set to all free when added.
`default_nettype none
module slot_reservation_table_core #(
  parameter int MAX_RESOURCES = srt_pkg::MAX_RESOURCES_DEF,
  parameter int MAX_SITES     = srt_pkg::MAX_SITES_DEF,
  parameter int KEY_BITS      = srt_pkg::KEY_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [srt_pkg::REQ_W-1:0]          req_type,
  input  wire logic [srt_pkg::KEY_W-1:0]          resource_key,
  input  wire logic [srt_pkg::KEY_W-1:0]          site_key,
  input  wire logic [srt_pkg::SIDX_W-1:0]         site_index,
  input  wire logic [srt_pkg::DAY_W-1:0]          day,
  output logic                                    valid,
  output logic      [srt_pkg::STATUS_W-1:0]       status,
  output logic      [srt_pkg::ENTRY_W-1:0]        entry_index,
  output logic      [srt_pkg::ROW_SITE_W-1:0]     row_site,
  output logic      [srt_pkg::DAYS-1:0]           week_free,
  output logic                                    last
);

  srt_pkg::cmd_t    push_cmd;
  srt_pkg::cmd_t    head_cmd;
  srt_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  srt_front #(.KEY_BITS(KEY_BITS)) u_front (
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .resource_key (resource_key),
    .site_key     (site_key),
    .site_index   (site_index),
    .day          (day),
    .q_stat       (q_stat),
    .push         (push),
    .cmd          (push_cmd)
  );

  srt_queue #(.DEPTH(srt_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .q_stat    (q_stat)
  );

  srt_back #(
    .MAX_RESOURCES (MAX_RESOURCES),
    .MAX_SITES     (MAX_SITES),
    .KEY_BITS      (KEY_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_head      (head_cmd),
    .q_pop       (pop),
    .valid       (valid),
    .status      (status),
    .entry_index (entry_index),
    .row_site    (row_site),
    .week_free   (week_free),
    .last        (last)
  );

`ifndef SYNTH
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("Query rows were not streamed back to back.");

  a_week_only_ok: assert property (@(posedge clk) disable iff (rst)
    valid && (week_free != '0) |-> status == srt_pkg::ST_OK)
    else $error("Free days reported on a failed request.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("Result strobe right after reset.");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |=> !$past(push))
    else $error("Word pushed into a full queue.");
`endif

endmodule
`default_nettype wire

### hw/rtl/srt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/srt_front.sv
// Front end: accepts request words, trims keys and classifies the day range.
`default_nettype none
module srt_front #(
  parameter int KEY_BITS = srt_pkg::KEY_BITS_DEF
) (
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [srt_pkg::REQ_W-1:0]     req_type,
  input  wire logic [srt_pkg::KEY_W-1:0]     resource_key,
  input  wire logic [srt_pkg::KEY_W-1:0]     site_key,
  input  wire logic [srt_pkg::SIDX_W-1:0]    site_index,
  input  wire logic [srt_pkg::DAY_W-1:0]     day,
  input  wire srt_pkg::q_stat_t              q_stat,
  output logic                               push,
  output srt_pkg::cmd_t                      cmd
);

  localparam logic [srt_pkg::KEY_W-1:0] KEY_MASK =
    {srt_pkg::KEY_W{1'b1}} >> (srt_pkg::KEY_W - KEY_BITS);

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    cmd.req     = srt_pkg::req_t'(req_type);
    cmd.rkey    = resource_key & KEY_MASK;
    cmd.skey    = site_key & KEY_MASK;
    cmd.sidx    = site_index;
    cmd.day     = day;
    cmd.day_bad = (day >= srt_pkg::DAY_W'(srt_pkg::DAYS));
  end

endmodule
`default_nettype wire

### hw/rtl/srt_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module srt_queue #(
  parameter int DEPTH = srt_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire srt_pkg::cmd_t push_data,
  input  wire logic         pop,
  output srt_pkg::cmd_t     head,
  output srt_pkg::q_stat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srt_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rptr];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/srt_back.sv
// Back end: key scans, table updates, slot claims and query row streaming.
`default_nettype none
module srt_back #(
  parameter int MAX_RESOURCES = srt_pkg::MAX_RESOURCES_DEF,
  parameter int MAX_SITES     = srt_pkg::MAX_SITES_DEF,
  parameter int KEY_BITS      = srt_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire srt_pkg::q_stat_t                  q_stat,
  input  wire srt_pkg::cmd_t                     q_head,
  output logic                                   q_pop,
  output logic                                   valid,
  output logic      [srt_pkg::STATUS_W-1:0]      status,
  output logic      [srt_pkg::ENTRY_W-1:0]       entry_index,
  output logic      [srt_pkg::ROW_SITE_W-1:0]    row_site,
  output logic      [srt_pkg::DAYS-1:0]          week_free,
  output logic                                   last
);

  localparam int RES_IW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RES_CW   = $clog2(MAX_RESOURCES + 1);
  localparam int SITE_IW  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int SITE_CW  = $clog2(MAX_SITES + 1);
  localparam int SCAN_W   = (RES_CW > SITE_CW) ? RES_CW : SITE_CW;
  localparam int ROW_BITS = MAX_SITES * srt_pkg::DAYS;
  localparam int MAX_ROWS = (MAX_SITES < srt_pkg::MAX_RESULTS) ? MAX_SITES
                                                               : srt_pkg::MAX_RESULTS;
  localparam int ROW_IW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_RMW  = 5'b01000,
    S_ROWS = 5'b10000
  } state_t;

  state_t                      state, state_next;
  srt_pkg::cmd_t               cmd, cmd_next;
  logic [SCAN_W-1:0]           idx, idx_next;
  logic [SCAN_W-1:0]           rd_idx, rd_idx_next;
  logic                        rd_pend, rd_pend_next;
  logic                        found, found_next;
  logic [SCAN_W-1:0]           hit, hit_next;
  logic [SITE_CW-1:0]          site_count, site_count_next;
  logic [RES_CW-1:0]           resource_count, resource_count_next;
  logic [ROW_IW-1:0]           row_cnt, row_cnt_next;
  logic [ROW_IW-1:0]           rows_m1, rows_m1_next;
  logic                        valid_next;
  srt_pkg::status_t            status_next;
  logic [srt_pkg::ENTRY_W-1:0] entry_next;
  logic [srt_pkg::ROW_SITE_W-1:0] row_site_next;
  logic [srt_pkg::DAYS-1:0]    week_next;
  logic                        last_next;

  logic                        site_we, site_re;
  logic                        res_we, res_re;
  logic                        free_we, free_re;
  logic [KEY_BITS-1:0]         site_rdata, res_rdata, key_rdata, key_wdata;
  logic [KEY_BITS-1:0]         cmd_key;
  logic [ROW_BITS-1:0]         free_rdata, free_wdata, row_new;
  logic [RES_IW-1:0]           free_waddr;
  logic [srt_pkg::DAYS-1:0]    row_arr [MAX_SITES];
  logic [SITE_IW-1:0]          sel;
  logic [SCAN_W-1:0]           limit;
  logic                        key_match;
  logic                        range_bad;

  srt_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_SITES)) u_site_keys (
    .clk   (clk),
    .we    (site_we),
    .waddr (SITE_IW'(site_count)),
    .wdata (key_wdata),
    .re    (site_re),
    .raddr (SITE_IW'(idx)),
    .rdata (site_rdata)
  );

  srt_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_RESOURCES)) u_res_keys (
    .clk   (clk),
    .we    (res_we),
    .waddr (RES_IW'(resource_count)),
    .wdata (key_wdata),
    .re    (res_re),
    .raddr (RES_IW'(idx)),
    .rdata (res_rdata)
  );

  srt_ram #(.WIDTH(ROW_BITS), .DEPTH(MAX_RESOURCES)) u_free_bits (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .re    (free_re),
    .raddr (RES_IW'(hit)),
    .rdata (free_rdata)
  );

  assign sel       = SITE_IW'(cmd.sidx);
  assign cmd_key   = (cmd.req == srt_pkg::REQ_ADD_SITE) ? KEY_BITS'(cmd.skey)
                                                        : KEY_BITS'(cmd.rkey);
  assign key_wdata = cmd_key;
  assign key_rdata = (cmd.req == srt_pkg::REQ_ADD_SITE) ? site_rdata : res_rdata;
  assign key_match = rd_pend && (key_rdata == cmd_key);
  assign limit     = (cmd.req == srt_pkg::REQ_ADD_SITE) ? SCAN_W'(site_count)
                                                        : SCAN_W'(resource_count);
  assign range_bad = cmd.day_bad || (8'(cmd.sidx) >= 8'(site_count));

  always_comb begin
    for (int s = 0; s < MAX_SITES; s++) begin
      row_arr[s] = free_rdata[s*srt_pkg::DAYS +: srt_pkg::DAYS];
      for (int d = 0; d < srt_pkg::DAYS; d++) begin
        row_new[s*srt_pkg::DAYS + d] = free_rdata[s*srt_pkg::DAYS + d] &&
          !((sel == SITE_IW'(s)) && (cmd.day == srt_pkg::DAY_W'(d)));
      end
    end
  end

  always_comb begin
    state_next          = state;
    cmd_next            = cmd;
    idx_next            = idx;
    rd_idx_next         = rd_idx;
    rd_pend_next        = rd_pend;
    found_next          = found;
    hit_next            = hit;
    site_count_next     = site_count;
    resource_count_next = resource_count;
    row_cnt_next        = row_cnt;
    rows_m1_next        = rows_m1;
    valid_next          = 1'b0;
    status_next         = srt_pkg::ST_OK;
    entry_next          = '0;
    row_site_next       = '0;
    week_next           = '0;
    last_next           = 1'b0;
    q_pop               = 1'b0;
    site_we             = 1'b0;
    site_re             = 1'b0;
    res_we              = 1'b0;
    res_re              = 1'b0;
    free_we             = 1'b0;
    free_re             = 1'b0;
    free_waddr          = RES_IW'(hit);
    free_wdata          = row_new;

    unique case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop        = 1'b1;
          cmd_next     = q_head;
          idx_next     = '0;
          rd_pend_next = 1'b0;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_match) begin
          found_next   = 1'b1;
          hit_next     = rd_idx;
          rd_pend_next = 1'b0;
          state_next   = S_EXEC;
        end else if (idx == limit) begin
          found_next   = 1'b0;
          hit_next     = '0;
          rd_pend_next = 1'b0;
          state_next   = S_EXEC;
        end else begin
          site_re      = (cmd.req == srt_pkg::REQ_ADD_SITE);
          res_re       = (cmd.req != srt_pkg::REQ_ADD_SITE);
          rd_idx_next  = idx;
          idx_next     = SCAN_W'(idx + 1'b1);
          rd_pend_next = 1'b1;
        end
      end
      S_EXEC: begin
        valid_next = 1'b1;
        last_next  = 1'b1;
        state_next = S_IDLE;
        unique case (cmd.req)
          srt_pkg::REQ_ADD_SITE: begin
            if (found) begin
              status_next = srt_pkg::ST_DUP;
              entry_next  = srt_pkg::ENTRY_W'(hit);
            end else if (site_count == SITE_CW'(MAX_SITES)) begin
              status_next = srt_pkg::ST_FULL;
            end else begin
              site_we         = 1'b1;
              entry_next      = srt_pkg::ENTRY_W'(site_count);
              site_count_next = SITE_CW'(site_count + 1'b1);
            end
          end
          srt_pkg::REQ_ADD_RES: begin
            if (found) begin
              status_next = srt_pkg::ST_DUP;
              entry_next  = srt_pkg::ENTRY_W'(hit);
            end else if (resource_count == RES_CW'(MAX_RESOURCES)) begin
              status_next = srt_pkg::ST_FULL;
            end else begin
              res_we              = 1'b1;
              free_we             = 1'b1;
              free_waddr          = RES_IW'(resource_count);
              free_wdata          = '1;
              entry_next          = srt_pkg::ENTRY_W'(resource_count);
              resource_count_next = RES_CW'(resource_count + 1'b1);
            end
          end
          srt_pkg::REQ_RESERVE: begin
            entry_next = srt_pkg::ENTRY_W'(hit);
            if (!found) begin
              status_next = srt_pkg::ST_NOT_FOUND;
              entry_next  = '0;
            end else if (range_bad) begin
              status_next = srt_pkg::ST_RANGE;
            end else begin
              valid_next = 1'b0;
              last_next  = 1'b0;
              free_re    = 1'b1;
              state_next = S_RMW;
            end
          end
          srt_pkg::REQ_QUERY: begin
            entry_next = srt_pkg::ENTRY_W'(hit);
            if (!found) begin
              status_next = srt_pkg::ST_NOT_FOUND;
              entry_next  = '0;
            end else if (site_count == '0) begin
              status_next = srt_pkg::ST_NO_SITES;
            end else begin
              valid_next   = 1'b0;
              last_next    = 1'b0;
              free_re      = 1'b1;
              row_cnt_next = '0;
              if (site_count >= SITE_CW'(MAX_ROWS)) begin
                rows_m1_next = ROW_IW'(MAX_ROWS - 1);
              end else begin
                rows_m1_next = ROW_IW'(SITE_CW'(site_count - 1'b1));
              end
              state_next = S_ROWS;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_RMW: begin
        valid_next = 1'b1;
        last_next  = 1'b1;
        entry_next = srt_pkg::ENTRY_W'(hit);
        state_next = S_IDLE;
        if (row_arr[sel][cmd.day]) begin
          free_we = 1'b1;
        end else begin
          status_next = srt_pkg::ST_TAKEN;
        end
      end
      S_ROWS: begin
        valid_next    = 1'b1;
        entry_next    = srt_pkg::ENTRY_W'(hit);
        row_site_next = srt_pkg::ROW_SITE_W'(row_cnt);
        week_next     = row_arr[SITE_IW'(row_cnt)];
        last_next     = (row_cnt == rows_m1);
        if (row_cnt == rows_m1) begin
          state_next = S_IDLE;
        end else begin
          row_cnt_next = ROW_IW'(row_cnt + 1'b1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd         <= cmd_next;
    idx         <= idx_next;
    rd_idx      <= rd_idx_next;
    found       <= found_next;
    hit         <= hit_next;
    row_cnt     <= row_cnt_next;
    rows_m1     <= rows_m1_next;
    status      <= status_next;
    entry_index <= entry_next;
    row_site    <= row_site_next;
    week_free   <= week_next;
    last        <= last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rd_pend        <= 1'b0;
      site_count     <= '0;
      resource_count <= '0;
      valid          <= 1'b0;
    end else begin
      state          <= state_next;
      rd_pend        <= rd_pend_next;
      site_count     <= site_count_next;
      resource_count <= resource_count_next;
      valid          <= valid_next;
    end
  end

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slot reservation table core: directed table, then random requests.
module testbench;
  import srt_pkg::*;

  localparam int RES_DEPTH  = MAX_RESOURCES_DEF;
  localparam int SITE_DEPTH = MAX_SITES_DEF;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_MIX  = 64'h5A5A_A5A5_0F0F_F0F0;
  localparam logic [KEY_W-1:0] KEY_ODD  = 64'h8000_0000_0000_0001;
  localparam logic [KEY_W-1:0] KEY_MISS = 64'h0123_4567_89AB_CDEF;

  typedef struct packed {
    req_t              req;
    logic [KEY_W-1:0]  rkey;
    logic [KEY_W-1:0]  skey;
    logic [SIDX_W-1:0] sidx;
    logic [DAY_W-1:0]  day;
  } word_t;

  typedef struct packed {
    status_t                 status;
    logic [ENTRY_W-1:0]      idx;
    logic [ROW_SITE_W-1:0]   site;
    logic [DAYS-1:0]         week;
    logic                    last;
  } reply_t;

  typedef struct packed {
    req_t               req;
    logic [KEY_W-1:0]   rkey;
    logic [KEY_W-1:0]   skey;
    logic [SIDX_W-1:0]  sidx;
    logic [DAY_W-1:0]   day;
    logic               typed;
    status_t            status;
    logic [ENTRY_W-1:0] idx;
  } plan_row_t;

  // Rows marked typed carry their reply; the others are checked against the table mirror.
  localparam int PLAN_LEN = 23;
  plan_row_t plan [PLAN_LEN] = '{
    '{REQ_QUERY,    '0,       KEY_ONES, 4'd0,  3'd0, 1'b1, ST_NOT_FOUND, 6'd0},
    '{REQ_RESERVE,  KEY_ONES, KEY_ONES, 4'd15, 3'd7, 1'b1, ST_NOT_FOUND, 6'd0},
    '{REQ_ADD_RES,  '0,       KEY_ONES, 4'd15, 3'd7, 1'b1, ST_OK,        6'd0},
    '{REQ_ADD_RES,  KEY_ONES, '0,       4'd0,  3'd0, 1'b1, ST_OK,        6'd1},
    '{REQ_ADD_RES,  '0,       KEY_MIX,  4'd5,  3'd2, 1'b1, ST_DUP,       6'd0},
    '{REQ_QUERY,    '0,       '0,       4'd0,  3'd0, 1'b1, ST_NO_SITES,  6'd0},
    '{REQ_RESERVE,  KEY_ONES, '0,       4'd0,  3'd0, 1'b1, ST_RANGE,     6'd1},
    '{REQ_ADD_SITE, KEY_ONES, '0,       4'd15, 3'd7, 1'b1, ST_OK,        6'd0},
    '{REQ_ADD_SITE, '0,       KEY_ONES, 4'd0,  3'd0, 1'b1, ST_OK,        6'd1},
    '{REQ_ADD_SITE, KEY_MIX,  KEY_ONES, 4'd9,  3'd5, 1'b1, ST_DUP,       6'd1},
    '{REQ_RESERVE,  KEY_ONES, KEY_MIX,  4'd1,  3'd6, 1'b1, ST_OK,        6'd1},
    '{REQ_RESERVE,  KEY_ONES, '0,       4'd1,  3'd6, 1'b1, ST_TAKEN,     6'd1},
    '{REQ_RESERVE,  '0,       '0,       4'd0,  3'd7, 1'b1, ST_RANGE,     6'd0},
    '{REQ_RESERVE,  '0,       KEY_ONES, 4'd15, 3'd0, 1'b1, ST_RANGE,     6'd0},
    '{REQ_RESERVE,  '0,       '0,       4'd2,  3'd0, 1'b1, ST_RANGE,     6'd0},
    '{REQ_RESERVE,  '0,       '0,       4'd0,  3'd0, 1'b0, ST_OK,        6'd0},
    '{REQ_RESERVE,  '0,       KEY_MIX,  4'd1,  3'd3, 1'b0, ST_OK,        6'd0},
    '{REQ_QUERY,    KEY_ONES, '0,       4'd0,  3'd0, 1'b0, ST_OK,        6'd0},
    '{REQ_QUERY,    '0,       KEY_ONES, 4'd15, 3'd7, 1'b0, ST_OK,        6'd0},
    '{REQ_ADD_RES,  KEY_MIX,  KEY_ODD,  4'd3,  3'd1, 1'b1, ST_OK,        6'd2},
    '{REQ_RESERVE,  KEY_MISS, '0,       4'd0,  3'd0, 1'b1, ST_NOT_FOUND, 6'd0},
    '{REQ_ADD_SITE, KEY_MISS, KEY_ODD,  4'd0,  3'd4, 1'b1, ST_OK,        6'd2},
    '{REQ_QUERY,    KEY_MIX,  '0,       4'd0,  3'd0, 1'b0, ST_OK,        6'd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [REQ_W-1:0]      req_type;
  logic [KEY_W-1:0]      resource_key;
  logic [KEY_W-1:0]      site_key;
  logic [SIDX_W-1:0]     site_index;
  logic [DAY_W-1:0]      day;
  logic                  valid;
  logic [STATUS_W-1:0]   status;
  logic [ENTRY_W-1:0]    entry_index;
  logic [ROW_SITE_W-1:0] row_site;
  logic [DAYS-1:0]       week_free;
  logic                  last;

  slot_reservation_table_core DUT (
    .clk, .rst, .start, .busy, .req_type, .resource_key, .site_key, .site_index, .day,
    .valid, .status, .entry_index, .row_site, .week_free, .last
  );

  logic [KEY_W-1:0] res_tab [RES_DEPTH];
  logic [KEY_W-1:0] site_tab [SITE_DEPTH];
  logic [DAYS-1:0]  free_map [RES_DEPTH][SITE_DEPTH];
  int               res_cnt;
  int               site_cnt;

  reply_t pending [$];
  reply_t want;
  reply_t got;
  int     fail_count;
  int     accepted;
  int     replies_seen;
  int     status_hits [8];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int find_res(input logic [KEY_W-1:0] k);
    for (int i = 0; i < res_cnt; i++) begin
      if (res_tab[i] == k) return i;
    end
    return res_cnt;
  endfunction

  function automatic int find_site(input logic [KEY_W-1:0] k);
    for (int i = 0; i < site_cnt; i++) begin
      if (site_tab[i] == k) return i;
    end
    return site_cnt;
  endfunction

  // Updates the table mirror for one request and, when keep is set, queues the replies it should produce.
  function automatic void serve_request(input word_t w, input bit keep);
    int hit;
    reply_t r;
    r = '0;
    r.last = 1'b1;
    case (w.req)
      REQ_ADD_SITE: begin
        hit = find_site(w.skey);
        if (hit < site_cnt) begin
          r.status = ST_DUP;
          r.idx = ENTRY_W'(hit);
        end else if (site_cnt >= SITE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          site_tab[site_cnt] = w.skey;
          r.status = ST_OK;
          r.idx = ENTRY_W'(site_cnt);
          site_cnt++;
        end
        if (keep) pending.push_back(r);
      end
      REQ_ADD_RES: begin
        hit = find_res(w.rkey);
        if (hit < res_cnt) begin
          r.status = ST_DUP;
          r.idx = ENTRY_W'(hit);
        end else if (res_cnt >= RES_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          res_tab[res_cnt] = w.rkey;
          for (int s = 0; s < SITE_DEPTH; s++) free_map[res_cnt][s] = '1;
          r.status = ST_OK;
          r.idx = ENTRY_W'(res_cnt);
          res_cnt++;
        end
        if (keep) pending.push_back(r);
      end
      default: begin
        hit = find_res(w.rkey);
        if (hit >= res_cnt) begin
          r.status = ST_NOT_FOUND;
          if (keep) pending.push_back(r);
        end else if (w.req == REQ_RESERVE) begin
          r.idx = ENTRY_W'(hit);
          if (int'(w.sidx) >= site_cnt || int'(w.day) >= DAYS) begin
            r.status = ST_RANGE;
          end else if (free_map[hit][w.sidx][w.day]) begin
            free_map[hit][w.sidx][w.day] = 1'b0;
            r.status = ST_OK;
          end else begin
            r.status = ST_TAKEN;
          end
          if (keep) pending.push_back(r);
        end else if (site_cnt == 0) begin
          r.status = ST_NO_SITES;
          r.idx = ENTRY_W'(hit);
          if (keep) pending.push_back(r);
        end else begin
          for (int s = 0; s < site_cnt && s < MAX_RESULTS; s++) begin
            r.status = ST_OK;
            r.idx = ENTRY_W'(hit);
            r.site = ROW_SITE_W'(s);
            r.week = free_map[hit][s];
            r.last = (s + 1 == site_cnt || s + 1 == MAX_RESULTS);
            if (keep) pending.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Mostly requests on registered keys and sites, with some misses and range errors.
  function automatic word_t random_word();
    word_t w;
    int p;
    int k;
    w.rkey = {$urandom, $urandom};
    w.skey = {$urandom, $urandom};
    w.sidx = SIDX_W'($urandom);
    w.day  = DAY_W'($urandom);
    p = $urandom_range(0, 99);
    if (p < 12) begin
      w.req = REQ_ADD_SITE;
      if (site_cnt > 0 && $urandom_range(0, 3) == 0)
        w.skey = site_tab[$urandom_range(0, site_cnt - 1)];
    end else if (p < 34) begin
      w.req = REQ_ADD_RES;
      if (res_cnt > 0 && $urandom_range(0, 4) == 0)
        w.rkey = res_tab[$urandom_range(0, res_cnt - 1)];
    end else begin
      w.req = (p < 74) ? REQ_RESERVE : REQ_QUERY;
      if (res_cnt > 0 && $urandom_range(0, 6) != 0) begin
        k = (res_cnt > 4 && $urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(0, res_cnt - 1);
        w.rkey = res_tab[k];
      end
      if (w.req == REQ_RESERVE) begin
        if (site_cnt > 0 && $urandom_range(0, 7) != 0)
          w.sidx = SIDX_W'($urandom_range(0, site_cnt - 1));
        w.day = ($urandom_range(0, 9) == 0) ? DAY_W'(7) : DAY_W'($urandom_range(0, DAYS - 1));
      end
    end
    return w;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic issue(input word_t w, input bit typed, input reply_t typed_reply);
    start        <= 1'b1;
    req_type     <= w.req;
    resource_key <= w.rkey;
    site_key     <= w.skey;
    site_index   <= w.sidx;
    day          <= w.day;
    @(posedge clk);
    while (busy) @(posedge clk);
    serve_request(w, !typed);
    if (typed) pending.push_back(typed_reply);
    accepted++;
    @(negedge clk);
  endtask

  task automatic drain_all();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && valid === 1'b1) begin
      replies_seen++;
      if (status < 8) status_hits[status]++;
      got = '{status_t'(status), entry_index, row_site, week_free, last};
      if (pending.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected word: status %0d index %0d site %0d week %h last %b",
                   $realtime, got.status, got.idx, got.site, got.week, got.last);
        fail_count++;
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("%0t: mismatch: expected status %0d index %0d site %0d week %h last %b, got status %0d index %0d site %0d week %h last %b",
                     $realtime, want.status, want.idx, want.site, want.week, want.last,
                     got.status, got.idx, got.site, got.week, got.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d words still expected.", pending.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    word_t  w;
    reply_t r;
    int     burst_left;
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = '0;
    resource_key = '0;
    site_key     = '0;
    site_index   = '0;
    day          = '0;
    res_cnt      = 0;
    site_cnt     = 0;
    fail_count   = 0;
    accepted     = 0;
    replies_seen = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (free_map[i, j]) free_map[i][j] = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      w = '{plan[i].req, plan[i].rkey, plan[i].skey, plan[i].sidx, plan[i].day};
      r = '{plan[i].status, plan[i].idx, '0, '0, 1'b1};
      issue(w, plan[i].typed, r);
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
    end
    drain_all();

    burst_left = $urandom_range(1, 10);
    for (int n = 0; n < 450; n++) begin
      if (n == 200) drain_all();
      issue(random_word(), 1'b0, '0);
      burst_left--;
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      end
    end

    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("Run covered %0d requests and %0d result words; %0d sites and %0d resources registered.",
             accepted, replies_seen, site_cnt, res_cnt);
    $display("Words by status: ok %0d, duplicate %0d, full %0d, not found %0d, range %0d, taken %0d, no sites %0d.",
             status_hits[ST_OK], status_hits[ST_DUP], status_hits[ST_FULL],
             status_hits[ST_NOT_FOUND], status_hits[ST_RANGE], status_hits[ST_TAKEN],
             status_hits[ST_NO_SITES]);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total.", fail_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
